[sv/assert_macros.svh]
// Assertion macros for the RTL files (used by esm_queue).
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTH
// property checked on the rising edge, off while reset is low
`define ASSERT_IMPL(lbl, clk, rstn, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) prop) else $error(msg);
// condition that must never be seen
`define ASSERT_NEVER(lbl, clk, rstn, cond, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) !(cond)) else $error(msg);
`else
`define ASSERT_IMPL(lbl, clk, rstn, prop, msg)
`define ASSERT_NEVER(lbl, clk, rstn, cond, msg)
`endif
`endif

[sv/esm_pkg.sv]
// Types, constants and helpers of the event stream to MIDI converter.
package esm_pkg;

  typedef enum logic [3:0] {
    PH_DELTA, PH_CMD, PH_PEEK, PH_METATYPE, PH_METALEN,
    PH_SYSLEN, PH_PAYLOAD, PH_DATA, PH_SKIP
  } phase_e;

  typedef enum logic [1:0] {
    CMD_BYTE, CMD_DELTA, CMD_MARKER
  } cmd_kind_e;

  typedef enum logic [2:0] {
    BK_IDLE, BK_MUL, BK_ADD, BK_DIV, BK_FIN, BK_VLQ, BK_MARK
  } back_state_e;

  typedef struct packed {
    cmd_kind_e   kind;
    logic [7:0]  data;      // byte to send, or controller number for a marker
    logic [31:0] total;     // tick total for a delta
    logic        clr_rest;  // clear the remainder before this delta
    logic        last;
    logic        trk_end;
    logic        bad;
  } cmd_t;

  localparam int unsigned QUEUE_DEPTH = 4;
  localparam int unsigned DIV_BITS    = 50;

  localparam logic REG_TIME_BASE = 1'b0;
  localparam logic REG_TPS       = 1'b1;

  localparam logic [7:0] STATUS_META     = 8'hFF;
  localparam logic [7:0] STATUS_SYSEX    = 8'hF0;
  localparam logic [7:0] META_EOT        = 8'h2F;
  localparam logic [7:0] META_TEXT       = 8'h01;
  localparam logic [7:0] CTRL_DROP_LO    = 8'd102;
  localparam logic [7:0] CTRL_DROP_HI    = 8'd119;
  localparam logic [7:0] CTRL_LOOP_START = 8'd110;
  localparam logic [7:0] CTRL_LOOP_END   = 8'd111;
  localparam logic [3:0] LEN_LOOP_START  = 4'd10;
  localparam logic [3:0] LEN_LOOP_END    = 4'd8;

  function automatic cmd_t mk_cmd(cmd_kind_e k, logic [7:0] d, logic [31:0] t, logic c);
    cmd_t r;
    r          = '0;
    r.kind     = k;
    r.data     = d;
    r.total    = t;
    r.clr_rest = c;
    return r;
  endfunction

  // text of the loop marker meta events
  function automatic logic [7:0] loop_char(logic is_end, logic [3:0] i);
    logic [7:0] r;
    r = 8'h00;
    if (is_end) begin
      unique case (i)
        4'd0: r = 8'h4C; 4'd1: r = 8'h6F; 4'd2: r = 8'h6F; 4'd3: r = 8'h70;
        4'd4: r = 8'h20; 4'd5: r = 8'h65; 4'd6: r = 8'h6E; 4'd7: r = 8'h64;
        default: r = 8'h00;
      endcase
    end else begin
      unique case (i)
        4'd0: r = 8'h4C; 4'd1: r = 8'h6F; 4'd2: r = 8'h6F; 4'd3: r = 8'h70;
        4'd4: r = 8'h20; 4'd5: r = 8'h73; 4'd6: r = 8'h74; 4'd7: r = 8'h61;
        4'd8: r = 8'h72; 4'd9: r = 8'h74;
        default: r = 8'h00;
      endcase
    end
    return r;
  endfunction

endpackage

[sv/esm_queue.sv]
// Command queue between the parser and the output engine.
`include "assert_macros.svh"
module esm_queue
  import esm_pkg::*;
(
  input  logic clk_i,
  input  logic rst_ni,
  input  logic push_i,
  input  cmd_t cmd_i,
  output logic full_o,
  input  logic pop_i,
  output cmd_t cmd_o,
  output logic avail_o
);

  cmd_t       mem_q [QUEUE_DEPTH];
  logic [1:0] wr_q, rd_q;
  logic [2:0] cnt_q;

  assign full_o  = (cnt_q == 3'(QUEUE_DEPTH));
  assign avail_o = (cnt_q != 3'd0);
  assign cmd_o   = mem_q[rd_q];

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_q] <= cmd_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      if (push_i) wr_q <= wr_q + 2'd1;
      if (pop_i)  rd_q <= rd_q + 2'd1;
      cnt_q <= cnt_q + 3'(push_i) - 3'(pop_i);
    end
  end

  `ASSERT_NEVER(a_no_overflow, clk_i, rst_ni, push_i && full_o, "queue overflow")
  `ASSERT_NEVER(a_no_underflow, clk_i, rst_ni, pop_i && !avail_o, "queue underflow")
  `ASSERT_IMPL(a_fill, clk_i, rst_ni, (push_i && !pop_i) |=> (cnt_q == $past(cnt_q) + 3'd1), "count off")
endmodule

[sv/esm_front.sv]
// Parser: decodes source bytes and queues output commands.
module esm_front
  import esm_pkg::*;
(
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       in_valid_i,
  output logic       in_ready_o,
  input  logic [7:0] in_byte_i,
  input  logic       track_start_i,
  output logic       q_push_o,
  output cmd_t       q_cmd_o,
  input  logic       q_full_i
);

  phase_e      phase_q, ph;
  logic [31:0] acc_q, acc, tot_q, tot;
  logic [5:0]  sh_q, sh;
  logic [7:0]  rs_q, rs, hf_q, hf, bl_q, bl;
  logic        fin_q, fin, rclr_q, rclr;
  cmd_t        pend_q [3];
  cmd_t        cmds [3];
  logic [1:0]  pend_cnt_q, pend_idx_q, n;
  logic        endf, badf, do_open, do_feed;
  logic [7:0]  os, b;
  logic        accept;

  assign b          = in_byte_i;
  assign in_ready_o = (pend_cnt_q == 2'd0);
  assign accept     = in_valid_i && in_ready_o;
  assign q_push_o   = (pend_cnt_q != 2'd0) && !q_full_i;
  assign q_cmd_o    = pend_q[pend_idx_q];

  always_comb begin
    ph = phase_q; acc = acc_q; tot = tot_q; sh = sh_q; rs = rs_q; hf = hf_q;
    bl = bl_q; fin = fin_q; rclr = rclr_q;
    n = '0; cmds = '{default: '0};
    endf = 1'b0; badf = 1'b0; do_open = 1'b0; do_feed = 1'b0; os = '0;
    if (track_start_i) begin
      ph = PH_DELTA; acc = '0; tot = '0; sh = '0; rs = '0; hf = '0; bl = '0;
      fin = 1'b0; rclr = 1'b1;
    end
    if (!fin) begin
      case (ph)
        PH_DELTA: begin
          if (sh < 6'd32) acc = acc | ({25'd0, b[6:0]} << sh[4:0]);
          sh = (sh > 6'd28) ? 6'd35 : 6'(sh + 6'd7);
          if (b[7]) begin
            tot = tot + acc; acc = '0; sh = '0; ph = PH_CMD;
          end
        end
        PH_CMD: begin
          if (b[7:4] == 4'hB) begin
            hf = b; ph = PH_PEEK;
          end else if (b[7]) begin
            if (b > STATUS_SYSEX && b != STATUS_META) begin
              cmds[n] = mk_cmd(CMD_BYTE, b, '0, 1'b0); n = n + 2'd1;
              badf = 1'b1; fin = 1'b1; ph = PH_DELTA;
            end else begin
              cmds[n] = mk_cmd(CMD_DELTA, '0, tot, rclr); n = n + 2'd1;
              tot = '0; rclr = 1'b0;
              rs = b; do_open = 1'b1; os = b;
            end
          end else begin
            cmds[n] = mk_cmd(CMD_DELTA, '0, tot, rclr); n = n + 2'd1;
            tot = '0; rclr = 1'b0;
            if (rs[7:4] == 4'hB && (b == CTRL_LOOP_START || b == CTRL_LOOP_END)) begin
              cmds[n] = mk_cmd(CMD_MARKER, b, '0, 1'b0); n = n + 2'd1;
              ph = PH_SKIP;
            end else begin
              do_open = 1'b1; os = rs; do_feed = 1'b1;
            end
          end
        end
        PH_PEEK: begin
          if (b >= CTRL_DROP_LO && b <= CTRL_DROP_HI && b != CTRL_LOOP_START
              && b != CTRL_LOOP_END) begin
            ph = PH_SKIP;
          end else begin
            cmds[n] = mk_cmd(CMD_DELTA, '0, tot, rclr); n = n + 2'd1;
            tot = '0; rclr = 1'b0; rs = hf;
            if (b == CTRL_LOOP_START || b == CTRL_LOOP_END) begin
              cmds[n] = mk_cmd(CMD_MARKER, b, '0, 1'b0); n = n + 2'd1;
              ph = PH_SKIP;
            end else begin
              do_open = 1'b1; os = hf; do_feed = 1'b1;
            end
          end
        end
        PH_SKIP: ph = PH_DELTA;
        default: do_feed = 1'b1;
      endcase
      // status byte of an event is always sent
      if (do_open) begin
        cmds[n] = mk_cmd(CMD_BYTE, os, '0, 1'b0); n = n + 2'd1;
        if (os == STATUS_META) begin
          ph = PH_METATYPE;
        end else if (os == STATUS_SYSEX) begin
          ph = PH_SYSLEN;
        end else begin
          bl = (os >= 8'hC0 && os < 8'hE0) ? 8'd1 : 8'd2;
          ph = PH_DATA;
        end
      end
      if (do_feed) begin
        case (ph)
          PH_METATYPE: begin
            cmds[n] = mk_cmd(CMD_BYTE, b, '0, 1'b0); n = n + 2'd1;
            hf = b; ph = PH_METALEN;
          end
          PH_METALEN, PH_SYSLEN: begin
            cmds[n] = mk_cmd(CMD_BYTE, b, '0, 1'b0); n = n + 2'd1;
            if (b == 8'd0) begin
              if (ph == PH_METALEN && hf == META_EOT) begin
                endf = 1'b1; fin = 1'b1;
              end
              ph = PH_DELTA;
            end else begin
              bl = b; ph = PH_PAYLOAD;
            end
          end
          PH_PAYLOAD: begin
            cmds[n] = mk_cmd(CMD_BYTE, b, '0, 1'b0); n = n + 2'd1;
            bl = bl - 8'd1;
            if (bl == 8'd0) begin
              if (rs == STATUS_META && hf == META_EOT) begin
                endf = 1'b1; fin = 1'b1;
              end
              ph = PH_DELTA;
            end
          end
          PH_DATA: begin
            cmds[n] = mk_cmd(CMD_BYTE, b, '0, 1'b0); n = n + 2'd1;
            bl = bl - 8'd1;
            if (bl == 8'd0) ph = PH_DELTA;
          end
          default: ph = PH_DELTA;
        endcase
      end
      if (n != 2'd0) begin
        cmds[n - 2'd1].last    = 1'b1;
        cmds[n - 2'd1].trk_end = endf;
        cmds[n - 2'd1].bad     = badf;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) pend_q <= cmds;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= PH_DELTA; acc_q <= '0; tot_q <= '0; sh_q <= '0; rs_q <= '0;
      hf_q <= '0; bl_q <= '0; fin_q <= 1'b0; rclr_q <= 1'b0;
      pend_cnt_q <= '0; pend_idx_q <= '0;
    end else if (accept) begin
      phase_q <= ph; acc_q <= acc; tot_q <= tot; sh_q <= sh; rs_q <= rs;
      hf_q <= hf; bl_q <= bl; fin_q <= fin; rclr_q <= rclr;
      pend_cnt_q <= n; pend_idx_q <= '0;
    end else if (q_push_o) begin
      if (pend_idx_q == pend_cnt_q - 2'd1) begin
        pend_cnt_q <= '0; pend_idx_q <= '0;
      end else begin
        pend_idx_q <= pend_idx_q + 2'd1;
      end
    end
  end
endmodule

[sv/esm_back.sv]
// Output engine: byte pass-through, delta rescale, serial divide, VLQ and marker text.
module esm_back
  import esm_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        q_avail_i,
  input  cmd_t        q_cmd_i,
  output logic        q_pop_o,
  input  logic [15:0] time_base_i,
  input  logic [31:0] tps_i,
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output logic [7:0]  out_byte_o,
  output logic        last_of_run_o,
  output logic        track_end_o,
  output logic        bad_command_o
);

  back_state_e state_q, state_d;
  cmd_t        cmd_q;
  logic [48:0] prod_q;
  logic [49:0] div_q;
  logic [31:0] rem_q, rest_q, qv_q;
  logic [5:0]  cnt_q;
  logic [3:0]  idx_q;
  logic        lead_q;
  logic        ov_q, ol_q, oe_q, ob_q;
  logic [7:0]  obyte_q;

  logic        slot_free, emit, elast, skip, is_end;
  logic [7:0]  ebyte;
  logic [6:0]  g;
  logic [32:0] trial;
  logic        ge;
  logic [3:0]  mlen;

  assign slot_free = !ov_q || out_ready_i;
  assign trial     = {rem_q, div_q[DIV_BITS-1]};
  assign ge        = (trial >= {1'b0, tps_i});
  assign is_end    = (cmd_q.data == CTRL_LOOP_END);
  assign mlen      = is_end ? LEN_LOOP_END : LEN_LOOP_START;

  always_comb begin
    unique case (idx_q)
      4'd0:    g = {3'b000, qv_q[31:28]};
      4'd1:    g = qv_q[27:21];
      4'd2:    g = qv_q[20:14];
      4'd3:    g = qv_q[13:7];
      default: g = qv_q[6:0];
    endcase
  end
  // leading zero groups are not sent
  assign skip = (idx_q < 4'd4) && (g == 7'd0) && !lead_q;

  // next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      BK_IDLE: begin
        if (q_avail_i) begin
          if (q_cmd_i.kind == CMD_DELTA)       state_d = BK_MUL;
          else if (q_cmd_i.kind == CMD_MARKER) state_d = BK_MARK;
        end
      end
      BK_MUL:  state_d = BK_ADD;
      BK_ADD:  state_d = BK_DIV;
      BK_DIV:  if (cnt_q == 6'(DIV_BITS - 1)) state_d = BK_FIN;
      BK_FIN:  state_d = BK_VLQ;
      BK_VLQ:  if ((skip || slot_free) && idx_q == 4'd4) state_d = BK_IDLE;
      BK_MARK: if (slot_free && idx_q == mlen + 4'd2) state_d = BK_IDLE;
      default: state_d = BK_IDLE;
    endcase
  end

  // outputs
  always_comb begin
    q_pop_o = 1'b0; emit = 1'b0; ebyte = '0; elast = 1'b0;
    unique case (state_q)
      BK_IDLE: begin
        if (q_avail_i) begin
          if (q_cmd_i.kind == CMD_BYTE) begin
            q_pop_o = slot_free; emit = slot_free;
            ebyte = q_cmd_i.data; elast = q_cmd_i.last;
          end else begin
            q_pop_o = 1'b1;
          end
        end
      end
      BK_VLQ: begin
        emit  = !skip && slot_free;
        ebyte = {(idx_q != 4'd4), g};
        elast = (idx_q == 4'd4) && cmd_q.last;
      end
      BK_MARK: begin
        emit  = slot_free;
        elast = (idx_q == mlen + 4'd2) && cmd_q.last;
        if (idx_q == 4'd0)      ebyte = STATUS_META;
        else if (idx_q == 4'd1) ebyte = META_TEXT;
        else if (idx_q == 4'd2) ebyte = {4'd0, mlen};
        else                    ebyte = loop_char(is_end, idx_q - 4'd3);
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i) begin
    unique case (state_q)
      BK_IDLE: if (q_pop_o) cmd_q <= q_cmd_i;
      BK_MUL:  prod_q <= 49'(cmd_q.total) * 49'({time_base_i, 1'b0});
      BK_ADD:  div_q  <= {1'b0, prod_q} + {18'd0, rest_q};
      BK_DIV:  div_q  <= {div_q[DIV_BITS-2:0], ge};
      BK_FIN:  qv_q   <= (tps_i == '0) ? '1 : div_q[31:0];
      default: ;
    endcase
    if (state_q == BK_ADD) rem_q <= '0;
    else if (state_q == BK_DIV) rem_q <= ge ? 32'(trial - {1'b0, tps_i}) : trial[31:0];
    if (emit) begin
      obyte_q <= ebyte;
      ol_q    <= elast;
      oe_q    <= elast && ((state_q == BK_IDLE) ? q_cmd_i.trk_end : cmd_q.trk_end);
      ob_q    <= elast && ((state_q == BK_IDLE) ? q_cmd_i.bad : cmd_q.bad);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= BK_IDLE; rest_q <= '0; cnt_q <= '0; idx_q <= '0;
      lead_q <= 1'b0; ov_q <= 1'b0;
    end else begin
      state_q <= state_d;
      if (state_q == BK_IDLE && q_pop_o) begin
        idx_q <= '0; lead_q <= 1'b0;
        if (q_cmd_i.kind == CMD_DELTA && q_cmd_i.clr_rest) rest_q <= '0;
      end
      if (state_q == BK_ADD) cnt_q <= '0;
      if (state_q == BK_DIV) cnt_q <= cnt_q + 6'd1;
      if (state_q == BK_FIN) rest_q <= (tps_i == '0) ? '0 : rem_q;
      if (state_q == BK_VLQ && (skip || slot_free)) begin
        idx_q <= idx_q + 4'd1; lead_q <= lead_q || (g != 7'd0);
      end
      if (state_q == BK_MARK && slot_free) idx_q <= idx_q + 4'd1;
      if (emit) ov_q <= 1'b1;
      else if (out_ready_i) ov_q <= 1'b0;
    end
  end

  assign out_valid_o   = ov_q;
  assign out_byte_o    = obyte_q;
  assign last_of_run_o = ol_q;
  assign track_end_o   = oe_q;
  assign bad_command_o = ob_q;
endmodule

[sv/event_stream_to_midi_converter.sv]
// Top level: event stream to MIDI track converter with APB registers.
//
//  channel  dir  handshake               word
//  in       in   in_valid_i/in_ready_o   in_byte_i, track_start_i
//  out      out  out_valid_o/out_ready_i out_byte_o + last/end/bad flags
//  apb      in   psel/penable/pwrite     time_base (0x0), ticks_per_second (0x4)
//
// The parser decodes a source word when it takes it, then pushes the
// commands it queued (up to 3) one at a time while the queue has room,
// and takes no new word until all are pushed. A delta goes through the
// output engine as pop, multiply, add, 50-step restoring divide, finish
// and five VLQ groups (skipped leading zero groups are still stepped through).
// A loop marker is popped before its bytes. The serial divider sets the pace.
// Reset clears parse state, registers to 120 / 60, and empties the queue.
// The parser and engine stall independently through the 4-entry queue;
// the output register keeps its word while out_ready_i is low.
module event_stream_to_midi_converter
  import esm_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  logic [7:0]  in_byte_i,
  input  logic        track_start_i,
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output logic [7:0]  out_byte_o,
  output logic        last_of_run_o,
  output logic        track_end_o,
  output logic        bad_command_o,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);

  logic [15:0] time_base_q;
  logic [31:0] tps_q;
  logic        q_push, q_full, q_pop, q_avail;
  cmd_t        q_in, q_out;

  assign pready = 1'b1;
  // only one address bit decodes: two registers
  assign prdata = (paddr[2] == REG_TPS) ? tps_q : {16'd0, time_base_q};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      time_base_q <= 16'd120;
      tps_q       <= 32'd60;
    end else if (psel && penable && pwrite) begin
      if (paddr[2] == REG_TIME_BASE) time_base_q <= pwdata[15:0];
      else                           tps_q       <= pwdata;
    end
  end

  esm_front u_front (
    .clk_i, .rst_ni, .in_valid_i, .in_ready_o, .in_byte_i, .track_start_i,
    .q_push_o (q_push), .q_cmd_o (q_in), .q_full_i (q_full)
  );

  esm_queue u_queue (
    .clk_i, .rst_ni, .push_i (q_push), .cmd_i (q_in), .full_o (q_full),
    .pop_i (q_pop), .cmd_o (q_out), .avail_o (q_avail)
  );

  esm_back u_back (
    .clk_i, .rst_ni, .q_avail_i (q_avail), .q_cmd_i (q_out), .q_pop_o (q_pop),
    .time_base_i (time_base_q), .tps_i (tps_q),
    .out_valid_o, .out_ready_i, .out_byte_o, .last_of_run_o, .track_end_o,
    .bad_command_o
  );
endmodule

[bench/testbench.sv]
// Testbench of the event stream to MIDI track converter.
`timescale 1ns / 100ps

module testbench;
  import esm_pkg::*;

  // parse phases of the predictor
  typedef enum logic [3:0] {
    P_DELTA, P_CMD, P_PEEK, P_MTYPE, P_MLEN, P_SLEN, P_PAY, P_DATA, P_SKIP
  } pphase_e;

  localparam logic [2:0] ADDR_TIME_BASE = 3'd0;
  localparam logic [2:0] ADDR_TPS       = 3'd4;
  localparam int unsigned CYCLE_LIMIT   = 1500000;
  localparam int unsigned DRAIN_CYCLES  = 400;

  typedef struct packed {
    logic [7:0] data;
    logic       start;
  } in_word_t;

  typedef struct packed {
    logic [7:0] data;
    logic       last;
    logic       trk_end;
    logic       bad;
  } out_word_t;

  logic        clk_i;
  logic        rst_ni;
  logic        in_valid_i;
  logic        in_ready_o;
  logic [7:0]  in_byte_i;
  logic        track_start_i;
  logic        out_valid_o;
  logic        out_ready_i;
  logic [7:0]  out_byte_o;
  logic        last_of_run_o;
  logic        track_end_o;
  logic        bad_command_o;
  logic        psel;
  logic        penable;
  logic        pwrite;
  logic [2:0]  paddr;
  logic [31:0] pwdata;
  logic [31:0] prdata;
  logic        pready;

  event_stream_to_midi_converter u_top (.*);

  initial begin
    clk_i = 1'b0;
  end
  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  // predictor state
  logic [15:0] m_time_base;
  logic [31:0] m_tps;
  pphase_e     m_phase;
  logic [31:0] m_acc;
  logic [5:0]  m_shift;
  logic [31:0] m_total;
  logic [31:0] m_rest;
  logic [7:0]  m_status;
  logic [7:0]  m_held;
  logic [7:0]  m_left;
  logic        m_done;
  logic        m_end_flag;

  out_word_t   midi_expected[$];
  out_word_t   step_words[$];
  in_word_t    src_pending[$];

  int unsigned mismatches;
  int unsigned words_checked;
  int unsigned bytes_sent;
  int unsigned cycle_count;
  int unsigned hold_off_cycles;

  function automatic void put_byte(logic [7:0] b);
    out_word_t w;
    w = '0;
    w.data = b;
    if (step_words.size() < 18) step_words = {step_words, w};
  endfunction

  function automatic void clear_track();
    m_phase = P_DELTA;
    m_acc = '0;
    m_shift = '0;
    m_total = '0;
    m_rest = '0;
    m_status = '0;
    m_held = '0;
    m_left = '0;
    m_done = 1'b0;
  endfunction

  // rescale the tick total and emit it as a big-endian VLQ
  function automatic void put_scaled_delta();
    logic [63:0] scaled;
    logic [31:0] q;
    logic [6:0]  grp[5];
    bit          lead;
    scaled = {32'd0, m_total} * 64'd2 * {48'd0, m_time_base} + {32'd0, m_rest};
    if (m_tps == 0) begin
      q = 32'hFFFF_FFFF;
      m_rest = '0;
    end else begin
      q = 32'(scaled / {32'd0, m_tps});
      m_rest = 32'(scaled % {32'd0, m_tps});
    end
    grp[0] = {3'd0, q[31:28]};
    grp[1] = q[27:21];
    grp[2] = q[20:14];
    grp[3] = q[13:7];
    grp[4] = q[6:0];
    lead = 1'b0;
    for (int i = 0; i < 4; i++) begin
      if (grp[i] != 0) lead = 1'b1;
      if (lead) put_byte({1'b1, grp[i]});
    end
    put_byte({1'b0, grp[4]});
    m_total = '0;
  endfunction

  function automatic void finish_track();
    m_end_flag = 1'b1;
    m_done = 1'b1;
    m_phase = P_DELTA;
  endfunction

  function automatic void open_event(logic [7:0] s);
    put_byte(s);
    if (s == STATUS_META) m_phase = P_MTYPE;
    else if (s == STATUS_SYSEX) m_phase = P_SLEN;
    else begin
      m_left = (s >= 8'hC0 && s < 8'hE0) ? 8'd1 : 8'd2;
      m_phase = P_DATA;
    end
  endfunction

  function automatic void put_loop_marker(logic [7:0] c);
    string txt;
    txt = (c == CTRL_LOOP_END) ? "Loop end" : "Loop start";
    put_byte(STATUS_META);
    put_byte(META_TEXT);
    put_byte(8'(txt.len()));
    for (int i = 0; i < txt.len(); i++) put_byte(txt[i]);
    m_phase = P_SKIP;
  endfunction

  function automatic void copy_body(logic [7:0] b);
    case (m_phase)
      P_MTYPE: begin
        put_byte(b);
        m_held = b;
        m_phase = P_MLEN;
      end
      P_MLEN, P_SLEN: begin
        put_byte(b);
        if (b == 0) begin
          if (m_phase == P_MLEN && m_held == META_EOT) finish_track();
          else m_phase = P_DELTA;
        end else begin
          m_left = b;
          m_phase = P_PAY;
        end
      end
      P_PAY: begin
        put_byte(b);
        m_left--;
        if (m_left == 0) begin
          if (m_status == STATUS_META && m_held == META_EOT) finish_track();
          else m_phase = P_DELTA;
        end
      end
      P_DATA: begin
        put_byte(b);
        m_left--;
        if (m_left == 0) m_phase = P_DELTA;
      end
      default: m_phase = P_DELTA;
    endcase
  endfunction

  function automatic bit is_dropped_ctrl(logic [7:0] c);
    return c >= CTRL_DROP_LO && c <= CTRL_DROP_HI &&
           c != CTRL_LOOP_START && c != CTRL_LOOP_END;
  endfunction

  // works out the MIDI words caused by one source word
  function automatic void convert_word(in_word_t w);
    logic [7:0] b;
    logic [7:0] s;
    bit         bad;
    b = w.data;
    bad = 1'b0;
    step_words.delete();
    m_end_flag = 1'b0;
    if (w.start) clear_track();
    if (m_done) return;
    case (m_phase)
      P_DELTA: begin
        if (m_shift < 32) m_acc |= 32'({25'd0, b[6:0]} << m_shift);
        m_shift = (m_shift + 7 > 35) ? 6'd35 : m_shift + 6'd7;
        if (b[7]) begin
          m_total += m_acc;
          m_acc = '0;
          m_shift = '0;
          m_phase = P_CMD;
        end
      end
      P_CMD: begin
        if (b >= 8'hB0 && b <= 8'hBF) begin
          m_held = b;
          m_phase = P_PEEK;
        end else if (b[7]) begin
          if (b > STATUS_SYSEX && b != STATUS_META) begin
            put_byte(b);
            bad = 1'b1;
            m_done = 1'b1;
            m_phase = P_DELTA;
          end else begin
            put_scaled_delta();
            m_status = b;
            open_event(b);
          end
        end else begin
          // running status
          s = m_status;
          put_scaled_delta();
          if (s >= 8'hB0 && s <= 8'hBF && (b == CTRL_LOOP_START || b == CTRL_LOOP_END))
            put_loop_marker(b);
          else begin
            open_event(s);
            copy_body(b);
          end
        end
      end
      P_PEEK: begin
        if (is_dropped_ctrl(b)) m_phase = P_SKIP;
        else begin
          put_scaled_delta();
          m_status = m_held;
          if (b == CTRL_LOOP_START || b == CTRL_LOOP_END) put_loop_marker(b);
          else begin
            open_event(m_held);
            copy_body(b);
          end
        end
      end
      P_SKIP: m_phase = P_DELTA;
      default: copy_body(b);
    endcase
    if (step_words.size() > 0) begin
      step_words[$].last = 1'b1;
      step_words[$].trk_end = m_end_flag;
      step_words[$].bad = bad;
    end
    midi_expected = {midi_expected, step_words};
  endfunction

  // ---------------- stimulus building ----------------
  function automatic void push_src(logic [7:0] b, logic st = 1'b0);
    in_word_t w;
    w.data = b;
    w.start = st;
    src_pending = {src_pending, w};
  endfunction

  // delta of one to five bytes, last one carries the top bit
  function automatic void push_delta(int unsigned nbytes, bit big = 1'b0);
    for (int i = 0; i < nbytes; i++) begin
      logic [6:0] v;
      v = big ? 7'h7F : 7'($urandom_range(0, 127));
      push_src({(i == nbytes - 1), v});
    end
  endfunction

  function automatic void push_short_delta();
    push_delta($urandom_range(0, 3) == 0 ? $urandom_range(2, 5) : 1);
  endfunction

  // one random event (after its delta); the last kind is a lone random byte
  function automatic void push_event();
    int unsigned kind;
    int unsigned len;
    logic [7:0]  st;
    kind = $urandom_range(0, 9);
    case (kind)
      0, 1: begin
        st = 8'($urandom_range(8'h80, 8'hEF));
        if (st[7:4] == 4'hB) st = 8'h90;
        push_src(st);
        push_src(8'($urandom_range(0, 127)));
        if (!(st >= 8'hC0 && st < 8'hE0)) push_src(8'($urandom_range(0, 255)));
      end
      2, 3: begin
        push_src(8'($urandom_range(8'hB0, 8'hBF)));
        push_src(8'($urandom_range(100, 121)));
        push_src(8'($urandom_range(0, 255)));
      end
      4: begin
        // running status, first byte a data byte
        push_src(8'($urandom_range(0, 127)));
        push_src(8'($urandom_range(0, 255)));
        if ($urandom_range(0, 1) == 0) push_src(8'($urandom_range(0, 255)));
      end
      5, 6: begin
        push_src(STATUS_META);
        push_src(8'($urandom_range(1, 127)));
        len = $urandom_range(0, 4);
        push_src(8'(len));
        for (int i = 0; i < len; i++) push_src(8'($urandom_range(0, 255)));
      end
      7: begin
        push_src(STATUS_SYSEX);
        len = $urandom_range(0, 4);
        push_src(8'(len));
        for (int i = 0; i < len; i++) push_src(8'($urandom_range(0, 255)));
      end
      8: begin
        push_src(8'($urandom_range(8'hB0, 8'hBF)));
        push_src($urandom_range(0, 1) ? CTRL_LOOP_START : CTRL_LOOP_END);
        push_src(8'($urandom_range(0, 127)));
      end
      default: begin
        push_src(8'($urandom_range(0, 255)));
      end
    endcase
  endfunction

  function automatic void push_end_of_track();
    push_src(8'h80);
    push_src(STATUS_META);
    push_src(META_EOT);
    if ($urandom_range(0, 1) == 0) push_src(8'h00);
    else begin
      push_src(8'h01);
      push_src(8'($urandom_range(0, 255)));
    end
  endfunction

  function automatic void build_random_tracks(int unsigned target);
    int unsigned goal;
    goal = src_pending.size() + target;
    while (src_pending.size() < goal) begin
      push_src(8'($urandom_range(0, 255)) | 8'h80, 1'b1);
      push_src(8'h90);
      push_src(8'($urandom_range(0, 127)));
      push_src(8'($urandom_range(0, 127)));
      for (int e = $urandom_range(2, 10); e > 0; e--) begin
        push_short_delta();
        push_event();
      end
      case ($urandom_range(0, 5))
        0: begin
          // junk after a finished track
          push_end_of_track();
          push_src(8'($urandom_range(0, 255)));
        end
        1: begin
          push_src(8'h81);
          push_src(8'($urandom_range(8'hF1, 8'hFE)));
          push_src(8'($urandom_range(0, 255)));
        end
        default: push_end_of_track();
      endcase
    end
  endfunction

  // ---------------- driver ----------------
  int unsigned src_gap;
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_i <= 1'b0;
      in_byte_i <= '0;
      track_start_i <= 1'b0;
      src_gap <= 0;
    end else if (!in_valid_i || in_ready_o) begin
      if (in_valid_i) begin
        // accepted at this edge
        convert_word({in_byte_i, track_start_i});
        bytes_sent <= bytes_sent + 1;
      end
      if (src_gap != 0) begin
        in_valid_i <= 1'b0;
        src_gap <= src_gap - 1;
      end else if (src_pending.size() > 0) begin
        in_word_t w;
        w = src_pending.pop_front();
        in_valid_i <= 1'b1;
        in_byte_i <= w.data;
        track_start_i <= w.start;
        src_gap <= ($urandom_range(0, 2) == 0) ? $urandom_range(0, 14) : 0;
      end else begin
        in_valid_i <= 1'b0;
      end
    end
  end

  // ---------------- monitor and receiver stalls ----------------
  int unsigned sink_gap;
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_ready_i <= 1'b0;
      sink_gap <= 0;
    end else begin
      if (out_valid_o && out_ready_i) begin
        out_word_t got;
        out_word_t want;
        got = {out_byte_o, last_of_run_o, track_end_o, bad_command_o};
        words_checked <= words_checked + 1;
        if (midi_expected.size() == 0) begin
          mismatches++;
          if (mismatches <= 10)
            $display("ERROR: unexpected MIDI word byte=%h last=%b end=%b bad=%b",
                     got.data, got.last, got.trk_end, got.bad);
        end else begin
          want = midi_expected.pop_front();
          if (got != want) begin
            mismatches++;
            if (mismatches <= 10)
              $display("ERROR: MIDI word exp byte=%h last=%b end=%b bad=%b, got byte=%h last=%b end=%b bad=%b",
                       want.data, want.last, want.trk_end, want.bad,
                       got.data, got.last, got.trk_end, got.bad);
          end
        end
      end
      // long hold-off counted here; otherwise a random stall per word
      if (hold_off_cycles != 0) begin
        out_ready_i <= 1'b0;
        hold_off_cycles <= hold_off_cycles - 1;
      end else if (sink_gap != 0) begin
        out_ready_i <= 1'b0;
        sink_gap <= sink_gap - 1;
      end else begin
        out_ready_i <= 1'b1;
        if (out_valid_o && out_ready_i)
          sink_gap <= ($urandom_range(0, 2) == 0) ? $urandom_range(0, 14) : 0;
      end
    end
  end

  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("timeout after %0d cycles", cycle_count);
      $display("Verification failed");
      $finish;
    end
  end

  // ---------------- APB ----------------
  task automatic apb_write(logic [2:0] addr, logic [31:0] data);
    @(posedge clk_i);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= addr;
    pwdata <= data;
    @(posedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i); while (!pready);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
    if (addr == ADDR_TIME_BASE) m_time_base = data[15:0];
    else m_tps = data;
  endtask

  task automatic wait_idle();
    while (src_pending.size() != 0 || in_valid_i || midi_expected.size() != 0)
      @(posedge clk_i);
    // a word may still be in flight that causes no output
    repeat (DRAIN_CYCLES) @(posedge clk_i);
  endtask

  // ---------------- sequence ----------------
  initial begin
    logic [15:0] tb_set[4];
    logic [31:0] tps_set[4];
    rst_ni = 1'b0;
    psel = 1'b0;
    penable = 1'b0;
    pwrite = 1'b0;
    paddr = '0;
    pwdata = '0;
    mismatches = 0;
    words_checked = 0;
    bytes_sent = 0;
    cycle_count = 0;
    hold_off_cycles = 0;
    m_time_base = 16'd120;
    m_tps = 32'd60;
    clear_track();
    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // directed: reset settings, VLQ lengths, drops, markers, bad command
    push_src(8'h85, 1'b1);
    push_src(8'h90); push_src(8'h3C); push_src(8'h7F);
    push_delta(5, 1'b1);            // long delta, bits past 32 dropped
    push_src(8'hB3); push_src(8'd102); push_src(8'h00);   // dropped
    push_src(8'h81); push_src(8'hB3); push_src(CTRL_LOOP_START); push_src(8'h00);
    push_src(8'h80); push_src(CTRL_LOOP_END); push_src(8'h00);  // running status
    push_src(8'h80); push_src(8'hF0); push_src(8'h01); push_src(8'hF7);
    push_src(8'h80); push_src(8'hF5);                     // bad command
    push_src(8'h11);                                      // ignored after finish
    // running status with nothing seen yet
    push_src(8'h80, 1'b1); push_src(8'h40); push_src(8'hFF);
    push_end_of_track();
    wait_idle();

    // extremes of the registers, then random tracks
    tb_set  = '{16'hFFFF, 16'd0, 16'd480, 16'd1};
    tps_set = '{32'd1, 32'hFFFF_FFFF, 32'd0, 32'd7};
    for (int ph = 0; ph < 4; ph++) begin
      apb_write(ADDR_TIME_BASE, {16'd0, tb_set[ph]});
      apb_write(ADDR_TPS, tps_set[ph]);
      build_random_tracks(95);
      if (ph == 1) hold_off_cycles = 600;   // receiver backs off, queue fills
      wait_idle();
    end

    $display("Summary: %0d source words sent, %0d MIDI words checked,", bytes_sent,
             words_checked);
    $display("  over directed cases and four register settings incl. zero divisor.");
    if (mismatches == 0) begin
      $display("Verification passed");
    end else begin
      $display("%0d mismatches", mismatches);
      $display("Verification failed");
    end
    $finish;
  end

endmodule
